FILE: rtl/core/sspc_pkg.sv
// shared types and constants for the solovay-strassen primality check core
// no dependencies
`default_nettype none
package sspc_pkg;
    localparam int unsigned W = 31;

    typedef logic [W-1:0] val_t;

    localparam logic [2:0] RSN_PASS     = 3'd0;
    localparam logic [2:0] RSN_SMALL    = 3'd1;
    localparam logic [2:0] RSN_POWER    = 3'd2;
    localparam logic [2:0] RSN_MISMATCH = 3'd3;
    localparam logic [2:0] RSN_BAD_BASE = 3'd4;

    typedef struct packed {
        val_t candidate;
        val_t base;
    } sspc_in_t;

    typedef struct packed {
        logic       probably_prime;
        logic [2:0] verdict_reason;
        logic [1:0] jacobi_value;
        val_t       euler_power;
    } sspc_out_t;
endpackage
`default_nettype wire

FILE: rtl/core/solovay_strassen_primality_check_core.sv
// solovay-strassen primality check: bit-serial modular exponentiation and
// binary jacobi loop; depends on sspc_pkg
// the power takes one multiplier bit of a shift-and-add modular product per
//   cycle and the jacobi loop one halving or subtract step per cycle, with
//   each swap in a state of its own; a small, even or bad-base item skips
//   both and goes straight to the result
// throughput: one item at a time, busy high until the result strobe
// reset clears the controller; the receiver cannot stall the result strobe
`default_nettype none
module solovay_strassen_primality_check_core (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  start,
    input  wire sspc_pkg::sspc_in_t in_item,
    output logic                 busy,
    output logic                 done,
    output sspc_pkg::sspc_out_t  result
);
    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_NEXT, S_JRED, S_JSWAP, S_DONE
    } state_t;

    state_t             state_reg;
    sspc_pkg::val_t     n_reg, e_reg, r_reg, b_reg;
    sspc_pkg::val_t     x_reg, y_reg, acc_reg;
    logic               sq_reg;
    sspc_pkg::val_t     ja_reg, jn_reg;
    logic               sign_reg;
    sspc_pkg::sspc_out_t res_reg;
    logic               done_reg;

    // modular add helpers, one conditional subtract each
    logic [sspc_pkg::W:0] acc_sum, x_dbl;
    sspc_pkg::val_t       acc_new, x_new;
    assign acc_sum = {1'b0, acc_reg} + {1'b0, x_reg};
    assign acc_new = (acc_sum >= {1'b0, n_reg}) ?
                     sspc_pkg::W'(acc_sum - {1'b0, n_reg}) : acc_sum[sspc_pkg::W-1:0];
    assign x_dbl   = {x_reg, 1'b0};
    assign x_new   = (x_dbl >= {1'b0, n_reg}) ?
                     sspc_pkg::W'(x_dbl - {1'b0, n_reg}) : x_dbl[sspc_pkg::W-1:0];

    logic [2:0] n8;
    assign n8 = jn_reg[2:0];

    // input checks
    sspc_pkg::val_t cn, cb;
    logic small_bad, base_bad;
    assign cn = in_item.candidate;
    assign cb = in_item.base;
    assign small_bad = (cn < sspc_pkg::W'(5)) || !cn[0];
    assign base_bad  = (cb < sspc_pkg::W'(2)) || (cb > cn - sspc_pkg::W'(2));

    sspc_pkg::val_t nm1;
    assign nm1 = n_reg - sspc_pkg::W'(1);

    // controller and datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        n_reg <= cn;
                        if (small_bad || base_bad)
                        begin
                            res_reg <= '{probably_prime: 1'b0,
                                         verdict_reason: small_bad ? sspc_pkg::RSN_SMALL
                                                                   : sspc_pkg::RSN_BAD_BASE,
                                         jacobi_value: 2'b00,
                                         euler_power: '0};
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            res_reg <= '0;
                            e_reg <= cn >> 1;
                            r_reg <= sspc_pkg::W'(1);
                            b_reg <= cb;
                            ja_reg <= cb;
                            jn_reg <= cn;
                            sign_reg <= 1'b0;
                            state_reg <= S_NEXT;
                        end
                    end
                end
                S_NEXT:
                begin
                    // pick next product: r*b when bit set, then b*b
                    if (e_reg == '0)
                    begin
                        res_reg.euler_power <= r_reg;
                        if (r_reg != sspc_pkg::W'(1) && r_reg != nm1)
                        begin
                            res_reg.verdict_reason <= sspc_pkg::RSN_POWER;
                            state_reg <= S_DONE;
                        end
                        else
                            state_reg <= S_JRED;
                    end
                    else
                    begin
                        sq_reg  <= !e_reg[0];
                        x_reg   <= b_reg;
                        y_reg   <= e_reg[0] ? r_reg : b_reg;
                        acc_reg <= '0;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    // one multiplier bit per cycle
                    if (y_reg == '0)
                    begin
                        if (sq_reg)
                        begin
                            b_reg <= acc_reg;
                            e_reg <= e_reg >> 1;
                            state_reg <= S_NEXT;
                        end
                        else
                        begin
                            r_reg <= acc_reg;
                            sq_reg <= 1'b1;
                            x_reg <= b_reg;
                            y_reg <= b_reg;
                            acc_reg <= '0;
                        end
                    end
                    else
                    begin
                        if (y_reg[0])
                            acc_reg <= acc_new;
                        x_reg <= x_new;
                        y_reg <= y_reg >> 1;
                    end
                end
                S_JRED:
                begin
                    // strip factors of two, subtract n once, swap when a < n
                    if (ja_reg == '0)
                    begin
                        if (jn_reg == sspc_pkg::W'(1))
                        begin
                            res_reg.jacobi_value <= sign_reg ? 2'b11 : 2'b01;
                            if (sign_reg == (r_reg != sspc_pkg::W'(1)))
                            begin
                                res_reg.probably_prime <= 1'b1;
                                res_reg.verdict_reason <= sspc_pkg::RSN_PASS;
                            end
                            else
                                res_reg.verdict_reason <= sspc_pkg::RSN_MISMATCH;
                        end
                        else
                            res_reg.verdict_reason <= sspc_pkg::RSN_MISMATCH;
                        state_reg <= S_DONE;
                    end
                    else if (!ja_reg[0])
                    begin
                        ja_reg <= ja_reg >> 1;
                        if (n8 == 3'd3 || n8 == 3'd5)
                            sign_reg <= !sign_reg;
                    end
                    else if (ja_reg >= jn_reg)
                        ja_reg <= ja_reg - jn_reg;
                    else
                        state_reg <= S_JSWAP;
                end
                S_JSWAP:
                begin
                    // reciprocity swap
                    ja_reg <= jn_reg;
                    jn_reg <= ja_reg;
                    if (ja_reg[1:0] == 2'b11 && jn_reg[1:0] == 2'b11)
                        sign_reg <= !sign_reg;
                    state_reg <= S_JRED;
                end
                S_DONE:
                begin
                    done_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = res_reg;
endmodule
`default_nettype wire
